// ===== sv/lfu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LFU cache with LRU tie break.
package lfu_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] COUNT_NEW = 32'd1;
  localparam logic [DATA_W-1:0] MISS_VAL  = 32'hFFFF_FFFF;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } lfu_state_t;

  // Flags and data gathered by the scan pass.
  typedef struct packed {
    logic              found;
    logic              free_found;
    logic              vic_found;
    logic [DATA_W-1:0] found_value;
    logic [DATA_W-1:0] found_count;
    logic [DATA_W-1:0] vic_key;
  } scan_status_t;

endpackage

// ===== sv/lfu_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces.
interface lfu_req_if;
  import lfu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic                     evicted;
  logic signed [DATA_W-1:0] evicted_key;
  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

// ===== sv/lfu_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lfu_scan.sv =====
`timescale 1ns / 1ps
// Scan accumulator: key match, first free entry, used count and LFU/LRU victim.
module lfu_scan #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         step,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] idx,
  input  logic                         ent_valid,
  input  logic [lfu_pkg::DATA_W-1:0]   ent_key,
  input  logic [lfu_pkg::DATA_W-1:0]   ent_value,
  input  logic [lfu_pkg::DATA_W-1:0]   ent_count,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ent_age,
  input  logic [lfu_pkg::DATA_W-1:0]   req_key,
  output lfu_pkg::scan_status_t        status,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] found_idx,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] found_age,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] free_idx,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] vic_idx,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] vic_age,
  output logic [$clog2(CAPACITY+1)-1:0] used
);
  import lfu_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic              found;
  logic              free_found;
  logic              vic_found;
  logic [DATA_W-1:0] found_value;
  logic [DATA_W-1:0] found_count;
  logic [DATA_W-1:0] vic_key;
  logic [DATA_W-1:0] vic_count;
  logic              vic_take;

  // Lower count wins; equal count goes to the older entry.
  assign vic_take = ent_valid &&
                    (!vic_found || (ent_count < vic_count) ||
                     ((ent_count == vic_count) && (ent_age > vic_age)));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      vic_found  <= 1'b0;
      used       <= '0;
    end else if (step) begin
      if (ent_valid) begin
        used <= used + CW'(1);
        if (!found && (ent_key == req_key)) begin
          found       <= 1'b1;
          found_idx   <= idx;
          found_age   <= ent_age;
          found_value <= ent_value;
          found_count <= ent_count;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (vic_take) begin
        vic_found <= 1'b1;
        vic_idx   <= idx;
        vic_age   <= ent_age;
        vic_count <= ent_count;
        vic_key   <= ent_key;
      end
    end
  end

  assign status = '{found:       found,
                    free_found:  free_found,
                    vic_found:   vic_found,
                    found_value: found_value,
                    found_count: found_count,
                    vic_key:     vic_key};

endmodule

// ===== sv/lfu_cache_lru_tiebreak.sv =====
`timescale 1ns / 1ps
// Top level: LFU key/value cache with LRU tie break, sequenced over one entry RAM.
//
// Each request takes one pass over all CAPACITY entries through the single
// read port of the entry RAM to find the key, the first free entry, the
// number in use and the eviction victim (lowest use count, oldest on a tie),
// then, when the cache changes, a second read-modify-write pass that bumps
// age ranks and writes the touched or new entry. The second pass runs for a
// get hit or an accepted put and is skipped for a get miss or a put while
// capacity_in_use is zero; both passes use the one read port. The result sits
// in an output register, so one finished item may wait there while the next
// is processed. Entry valid bits are flip-flops cleared by reset, so no
// clearing pass is needed.
module lfu_cache_lru_tiebreak #(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  lfu_req_if.sink                   req,
  lfu_rsp_if.source                 rsp,
  input  logic                      cfg_wen,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata
);
  import lfu_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
  localparam int RW   = 3 * DATA_W + AW;

  lfu_state_t state, state_next;

  logic [CFG_W-1:0]    capacity_in_use;
  logic [CAPACITY-1:0] entry_valid;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_m1;
  logic [AW-1:0]       proc_idx;
  logic                cnt_last;

  logic              req_cmd;
  logic [DATA_W-1:0] req_key;
  logic [DATA_W-1:0] req_val;

  // Update pass target and age threshold.
  logic [AW-1:0]     target;
  logic [DATA_W-1:0] tgt_key;
  logic [DATA_W-1:0] tgt_val;
  logic [DATA_W-1:0] tgt_count;
  logic [AW-1:0]     thr;
  logic              thr_all;

  logic              res_hit;
  logic [DATA_W-1:0] res_rv;
  logic              res_ev;
  logic [DATA_W-1:0] res_ek;

  logic              rsp_valid;
  logic              rsp_hit;
  logic [DATA_W-1:0] rsp_rv;
  logic              rsp_ev;
  logic [DATA_W-1:0] rsp_ek;

  // Control outputs.
  logic in_ready;
  logic accept;
  logic scan_step;
  logic upd_step;
  logic out_free;

  // RAM.
  logic              ram_we;
  logic [RW-1:0]     ram_wdata;
  logic [RW-1:0]     ram_rdata;
  logic [DATA_W-1:0] rd_key;
  logic [DATA_W-1:0] rd_val;
  logic [DATA_W-1:0] rd_count;
  logic [AW-1:0]     rd_age;
  logic [AW-1:0]     age_inc;

  // Scan results.
  scan_status_t  st;
  logic [AW-1:0] found_idx;
  logic [AW-1:0] found_age;
  logic [AW-1:0] free_idx;
  logic [AW-1:0] vic_idx;
  logic [AW-1:0] vic_age;
  logic [CW-1:0] used;

  // Decision.
  logic [CMPW-1:0]   cap_lim;
  logic [CMPW-1:0]   used_ext;
  logic              need_ev;
  logic              dec_update;
  logic              dec_set_valid;
  logic              dec_ev;
  logic [DATA_W-1:0] dec_rv;
  logic [DATA_W-1:0] dec_ek;
  logic [AW-1:0]     dec_target;
  logic [DATA_W-1:0] dec_val;
  logic [DATA_W-1:0] dec_count;
  logic [AW-1:0]     dec_thr;
  logic              dec_all;
  logic [DATA_W-1:0] count_inc;

  assign cnt_m1   = cnt - CW'(1);
  assign proc_idx = cnt_m1[AW-1:0];
  assign cnt_last = (cnt == CW'(CAPACITY));

  assign rd_age   = ram_rdata[AW-1:0];
  assign rd_count = ram_rdata[AW +: DATA_W];
  assign rd_val   = ram_rdata[AW + DATA_W +: DATA_W];
  assign rd_key   = ram_rdata[AW + 2*DATA_W +: DATA_W];

  lfu_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (proc_idx),
    .wdata (ram_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  lfu_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (accept),
    .step      (scan_step),
    .idx       (proc_idx),
    .ent_valid (entry_valid[proc_idx]),
    .ent_key   (rd_key),
    .ent_value (rd_val),
    .ent_count (rd_count),
    .ent_age   (rd_age),
    .req_key   (req_key),
    .status    (st),
    .found_idx (found_idx),
    .found_age (found_age),
    .free_idx  (free_idx),
    .vic_idx   (vic_idx),
    .vic_age   (vic_age),
    .used      (used)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = dec_update ? ST_UPDATE : ST_FINISH;
      end
      ST_UPDATE: begin
        if (cnt_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    scan_step = 1'b0;
    upd_step  = 1'b0;
    case (state)
      ST_IDLE:   in_ready  = 1'b1;
      ST_SCAN:   scan_step = (cnt != '0);
      ST_UPDATE: upd_step  = (cnt != '0);
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;
  assign out_free  = !rsp_valid || rsp.ready;

  // Read-modify-write of the entry read in the previous cycle.
  assign age_inc = (thr_all || (rd_age < thr)) ? (rd_age + AW'(1)) : rd_age;
  assign ram_we  = upd_step && ((proc_idx == target) || entry_valid[proc_idx]);
  always_comb begin
    if (proc_idx == target) begin
      ram_wdata = {tgt_key, tgt_val, tgt_count, AW'(0)};
    end else begin
      ram_wdata = {rd_key, rd_val, rd_count, age_inc};
    end
  end

  // Decision after the scan pass.
  assign count_inc = (st.found_count == COUNT_MAX) ? st.found_count
                                                   : (st.found_count + DATA_W'(1));
  assign cap_lim  = (CMPW'(capacity_in_use) > CMPW'(CAPACITY)) ? CMPW'(CAPACITY)
                                                               : CMPW'(capacity_in_use);
  assign used_ext = CMPW'(used);
  assign need_ev  = (used_ext >= cap_lim) || !st.free_found;

  always_comb begin
    dec_update    = 1'b0;
    dec_set_valid = 1'b0;
    dec_ev        = 1'b0;
    dec_rv        = '0;
    dec_ek        = '0;
    dec_target    = found_idx;
    dec_val       = st.found_value;
    dec_count     = count_inc;
    dec_thr       = found_age;
    dec_all       = 1'b0;
    if (req_cmd == CMD_GET) begin
      dec_rv     = st.found ? st.found_value : MISS_VAL;
      dec_update = st.found;
    end else if (capacity_in_use != '0) begin
      dec_val = req_val;
      if (st.found) begin
        dec_update = 1'b1;
      end else if (need_ev && st.vic_found) begin
        dec_update = 1'b1;
        dec_ev     = 1'b1;
        dec_ek     = st.vic_key;
        dec_target = vic_idx;
        dec_thr    = vic_age;
        dec_count  = COUNT_NEW;
      end else if (st.free_found) begin
        dec_update    = 1'b1;
        dec_set_valid = 1'b1;
        dec_target    = free_idx;
        dec_all       = 1'b1;
        dec_count     = COUNT_NEW;
      end
    end
  end

  // Sequencer registers and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      capacity_in_use <= CAP_RESET;
      entry_valid     <= '0;
      cnt             <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        capacity_in_use <= cfg_wdata;
      end
      // Load a finished item, or drop the one just taken.
      if ((state == ST_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            req_cmd <= req.command;
            req_key <= req.key;
            req_val <= req.value;
          end
        end
        ST_SCAN: begin
          cnt <= cnt_last ? '0 : cnt + CW'(1);
        end
        ST_DECIDE: begin
          cnt       <= '0;
          res_hit   <= st.found;
          res_rv    <= dec_rv;
          res_ev    <= dec_ev;
          res_ek    <= dec_ek;
          target    <= dec_target;
          tgt_key   <= req_key;
          tgt_val   <= dec_val;
          tgt_count <= dec_count;
          thr       <= dec_thr;
          thr_all   <= dec_all;
          if (dec_set_valid) begin
            entry_valid[dec_target] <= 1'b1;
          end
        end
        ST_UPDATE: begin
          cnt <= cnt_last ? '0 : cnt + CW'(1);
        end
        ST_FINISH: begin
          if (out_free) begin
            rsp_hit <= res_hit;
            rsp_rv  <= res_rv;
            rsp_ev  <= res_ev;
            rsp_ek  <= res_ek;
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.hit         = rsp_hit;
  assign rsp.read_value  = rsp_rv;
  assign rsp.evicted     = rsp_ev;
  assign rsp.evicted_key = rsp_ek;

endmodule
